[sv/epra_pkg.sv]
// ----------------------------------------------------------------------------
// Echo pulse range averager package
// Shared widths, constants and the item record that moves between stages.
// ----------------------------------------------------------------------------
package epra_pkg;

  localparam int TICK_W          = 16;
  localparam int DIST_W          = 16;
  localparam int SCALE_W         = 16;
  localparam int SAMPLES_DEFAULT = 20;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1415;
  localparam logic [TICK_W-1:0]  COUNT_MAX   = '1;

  // One item as it moves down the pipeline. The distance field is filled in
  // by the scale stage, and done by the accumulate stage.
  typedef struct packed {
    logic              fire;
    logic              sat;
    logic              done;
    logic [TICK_W-1:0] pulse;
    logic [DIST_W-1:0] distance;
  } epra_event_t;

endpackage

[sv/epra_edge.sv]
// ----------------------------------------------------------------------------
// Echo edge stage
// Detects echo edges and runs the saturating pulse tick counter.
// ----------------------------------------------------------------------------
module epra_edge import epra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  input  logic        up_level,
  input  logic        dn_ready,
  output logic        valid,
  output logic        ready,
  output epra_event_t item
);

  logic              echo_previous;
  logic              overrun_flag;
  logic [TICK_W-1:0] pulse_counter;
  logic [TICK_W-1:0] held_pulse;

  logic              overrun_flag_next;
  logic [TICK_W-1:0] pulse_counter_next;
  logic [TICK_W-1:0] held_pulse_next;
  epra_event_t       item_next;

  assign ready = !valid || dn_ready;

  always_comb begin
    overrun_flag_next  = overrun_flag;
    pulse_counter_next = pulse_counter;
    held_pulse_next    = held_pulse;
    item_next          = '0;
    if (!echo_previous && up_level) begin
      pulse_counter_next = '0;
      overrun_flag_next  = 1'b0;
    end else if (echo_previous) begin
      if (pulse_counter == COUNT_MAX) begin
        overrun_flag_next = 1'b1;
      end else begin
        pulse_counter_next = pulse_counter + 1'b1;
      end
      if (!up_level) begin
        held_pulse_next = pulse_counter_next;
        item_next.fire  = 1'b1;
        item_next.sat   = overrun_flag_next;
      end
    end
    item_next.pulse = held_pulse_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      echo_previous <= 1'b0;
      overrun_flag  <= 1'b0;
      pulse_counter <= '0;
      held_pulse    <= '0;
    end else if (ready) begin
      valid <= up_valid;
      if (up_valid) begin
        echo_previous <= up_level;
        overrun_flag  <= overrun_flag_next;
        pulse_counter <= pulse_counter_next;
        held_pulse    <= held_pulse_next;
        item          <= item_next;
      end
    end
  end

endmodule

[sv/epra_scale.sv]
// ----------------------------------------------------------------------------
// Distance scale stage
// Turns the finished pulse length into a distance with the Q0.16 factor.
// ----------------------------------------------------------------------------
module epra_scale import epra_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [SCALE_W-1:0] scale,
  input  logic               up_valid,
  input  epra_event_t        up_item,
  input  logic               dn_ready,
  output logic               valid,
  output logic               ready,
  output epra_event_t        item
);

  logic [DIST_W-1:0]         held_distance;
  logic [TICK_W+SCALE_W-1:0] product;
  logic [DIST_W-1:0]         dist_calc;
  epra_event_t               item_next;

  assign ready     = !valid || dn_ready;
  assign product   = {{SCALE_W{1'b0}}, up_item.pulse} * {{TICK_W{1'b0}}, scale};
  assign dist_calc = product[SCALE_W +: DIST_W];

  always_comb begin
    item_next          = up_item;
    item_next.distance = up_item.fire ? dist_calc : held_distance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      held_distance <= '0;
    end else if (ready) begin
      valid <= up_valid;
      if (up_valid) begin
        if (up_item.fire) begin
          held_distance <= dist_calc;
        end
        item <= item_next;
      end
    end
  end

endmodule

[sv/epra_accum.sv]
// ----------------------------------------------------------------------------
// Distance accumulate stage
// Sums distances over one block of pulses and marks the pulse that ends it.
// ----------------------------------------------------------------------------
module epra_accum import epra_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT,
  parameter int SUM_W   = DIST_W + $clog2(SAMPLES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  epra_event_t      up_item,
  input  logic             dn_ready,
  output logic             valid,
  output logic             ready,
  output epra_event_t      item,
  output logic [SUM_W-1:0] total
);

  localparam int IDX_W = $clog2(SAMPLES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES - 1);

  logic [IDX_W-1:0] sample_index;
  logic [SUM_W-1:0] distance_sum;
  logic [SUM_W-1:0] sum_added;
  logic             block_end;
  epra_event_t      item_next;

  assign ready     = !valid || dn_ready;
  assign sum_added = distance_sum + {{(SUM_W-DIST_W){1'b0}}, up_item.distance};
  assign block_end = up_item.fire && (sample_index == LAST_IDX);

  always_comb begin
    item_next      = up_item;
    item_next.done = block_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      sample_index <= '0;
      distance_sum <= '0;
    end else if (ready) begin
      valid <= up_valid;
      if (up_valid) begin
        if (up_item.fire) begin
          if (block_end) begin
            sample_index <= '0;
            distance_sum <= '0;
          end else begin
            sample_index <= sample_index + 1'b1;
            distance_sum <= sum_added;
          end
        end
        item  <= item_next;
        total <= sum_added;
      end
    end
  end

endmodule

[sv/epra_average.sv]
// ----------------------------------------------------------------------------
// Block average stage
// Divides a finished block sum by the block size and drives the result.
// ----------------------------------------------------------------------------
module epra_average import epra_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT,
  parameter int SUM_W   = DIST_W + $clog2(SAMPLES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  epra_event_t       up_item,
  input  logic [SUM_W-1:0]  up_total,
  input  logic              dn_ready,
  output logic              valid,
  output logic              ready,
  output epra_event_t       item,
  output logic [DIST_W-1:0] average
);

  // Division by the block size is a multiply by a rounded-up reciprocal.
  // With this shift the quotient is exact for every sum that fits SUM_W.
  localparam int SHIFT   = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W = SUM_W + 2;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  logic [DIST_W-1:0]        held_average;
  logic [SUM_W+RECIP_W-1:0] product;
  logic [DIST_W-1:0]        quotient;

  assign ready    = !valid || dn_ready;
  assign product  = {{RECIP_W{1'b0}}, up_total} * {{SUM_W{1'b0}}, RECIP};
  assign quotient = product[SHIFT +: DIST_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= 1'b0;
      held_average <= '0;
    end else if (ready) begin
      valid <= up_valid;
      if (up_valid) begin
        if (up_item.done) begin
          held_average <= quotient;
          average      <= quotient;
        end else begin
          average      <= held_average;
        end
        item <= up_item;
      end
    end
  end

endmodule

[sv/echo_pulse_range_averager.sv]
// ----------------------------------------------------------------------------
// Echo pulse range averager
// Measures echo pulses in ticks, scales them to distances and averages them
// over blocks of SAMPLES pulses.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   input     in_valid / in_stall   echo_level
//   output    out_valid / out_stall pulse_ticks, sample_distance,
//                                   average_distance, average_ready,
//                                   fire_trigger, count_saturated
//   config    cfg_wr_en             cfg_wr_data (distance scale, Q0.16)
//
// One item per cycle sustained while the output is not stalled. The accepting
// edge loads the input register, and the edge, scale multiply, accumulate
// and reciprocal multiply stages each register the item in turn on its way
// to the output. Reset is synchronous, clears the valid flags, counters and
// held values, and sets the scale to its default; payload registers are not
// reset, and there is no clearing pass. A stall on the output holds the last
// stage, and the stages behind it keep filling until the pipeline is full.
// ----------------------------------------------------------------------------
module echo_pulse_range_averager import epra_pkg::*; #(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               echo_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TICK_W-1:0]  pulse_ticks,
  output logic [DIST_W-1:0]  sample_distance,
  output logic [DIST_W-1:0]  average_distance,
  output logic               average_ready,
  output logic               fire_trigger,
  output logic               count_saturated,
  input  logic               cfg_wr_en,
  input  logic [SCALE_W-1:0] cfg_wr_data
);

  localparam int SUM_W = DIST_W + $clog2(SAMPLES);

  logic [SCALE_W-1:0] distance_scale;
  logic               in_reg_valid;
  logic               in_reg_level;
  logic               in_ready;

  logic               edge_valid, edge_ready;
  logic               scale_valid, scale_ready;
  logic               accum_valid, accum_ready;
  logic               avg_ready;
  epra_event_t        edge_item, scale_item, accum_item, avg_item;
  logic [SUM_W-1:0]   accum_total;

  assign in_ready = !in_reg_valid || edge_ready;
  assign in_stall = !in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_scale <= SCALE_RESET;
    end else if (cfg_wr_en) begin
      distance_scale <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
      if (in_valid) begin
        in_reg_level <= echo_level;
      end
    end
  end

  epra_edge u_edge (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_reg_valid),
    .up_level (in_reg_level),
    .dn_ready (scale_ready),
    .valid    (edge_valid),
    .ready    (edge_ready),
    .item     (edge_item)
  );

  epra_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .scale    (distance_scale),
    .up_valid (edge_valid),
    .up_item  (edge_item),
    .dn_ready (accum_ready),
    .valid    (scale_valid),
    .ready    (scale_ready),
    .item     (scale_item)
  );

  epra_accum #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .up_valid (scale_valid),
    .up_item  (scale_item),
    .dn_ready (avg_ready),
    .valid    (accum_valid),
    .ready    (accum_ready),
    .item     (accum_item),
    .total    (accum_total)
  );

  epra_average #(
    .SAMPLES (SAMPLES),
    .SUM_W   (SUM_W)
  ) u_average (
    .clk      (clk),
    .rst      (rst),
    .up_valid (accum_valid),
    .up_item  (accum_item),
    .up_total (accum_total),
    .dn_ready (!out_stall),
    .valid    (out_valid),
    .ready    (avg_ready),
    .item     (avg_item),
    .average  (average_distance)
  );

  assign pulse_ticks     = avg_item.pulse;
  assign sample_distance = avg_item.distance;
  assign average_ready   = avg_item.done;
  assign fire_trigger    = avg_item.fire;
  assign count_saturated = avg_item.sat;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Echo pulse range averager testbench
// Drives echo line samples through the valid/stall handshake with random
// sender bursts and receiver stalls, predicts every result item from a model
// of pulse timing, scaling and block averaging, and checks each result field.
// ----------------------------------------------------------------------------
module tb;
  import epra_pkg::*;

  localparam int BLOCK_LEN  = SAMPLES_DEFAULT;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 8;

  typedef struct {
    logic [TICK_W-1:0] pulse_ticks;
    logic [DIST_W-1:0] sample_distance;
    logic [DIST_W-1:0] average_distance;
    logic              average_ready;
    logic              fire_trigger;
    logic              count_saturated;
  } range_result_t;

  class range_scoreboard;
    logic [SCALE_W-1:0] scale;
    logic               echo_prev;
    logic [TICK_W-1:0]  pulse_cnt;
    logic               overrun;
    int                 pulse_index;
    logic [20:0]        dist_sum;
    logic [DIST_W-1:0]  held_avg;
    logic [TICK_W-1:0]  held_pulse;
    logic [DIST_W-1:0]  held_dist;
    range_result_t      expected_q[$];
    int                 errors;

    function new();
      scale       = SCALE_RESET;
      echo_prev   = 1'b0;
      pulse_cnt   = '0;
      overrun     = 1'b0;
      pulse_index = 0;
      dist_sum    = '0;
      held_avg    = '0;
      held_pulse  = '0;
      held_dist   = '0;
      errors      = 0;
    endfunction

    function void set_scale(logic [SCALE_W-1:0] value);
      scale = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the model by one echo sample and queue the result it produces.
    function void note_echo_sample(logic level);
      range_result_t r;
      logic [31:0]   product;
      r.average_ready   = 1'b0;
      r.fire_trigger    = 1'b0;
      r.count_saturated = 1'b0;
      if (!echo_prev && level) begin
        pulse_cnt = '0;
        overrun   = 1'b0;
      end else if (echo_prev) begin
        if (pulse_cnt == COUNT_MAX) begin
          overrun = 1'b1;
        end else begin
          pulse_cnt = pulse_cnt + 1'b1;
        end
        if (!level) begin
          product    = pulse_cnt * scale;
          held_pulse = pulse_cnt;
          held_dist  = product[31:16];
          dist_sum   = dist_sum + held_dist;
          r.fire_trigger    = 1'b1;
          r.count_saturated = overrun;
          if (pulse_index >= BLOCK_LEN - 1) begin
            held_avg    = DIST_W'(dist_sum / BLOCK_LEN);
            dist_sum    = '0;
            pulse_index = 0;
            r.average_ready = 1'b1;
          end else begin
            pulse_index++;
          end
        end
      end
      echo_prev          = level;
      r.pulse_ticks      = held_pulse;
      r.sample_distance  = held_dist;
      r.average_distance = held_avg;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(range_result_t got);
      range_result_t want;
      if (expected_q.size() == 0) begin
        $error("result item arrived with no expectation pending");
        errors++;
      end else begin
        want = expected_q.pop_front();
        compare_field("pulse_ticks", want.pulse_ticks, got.pulse_ticks);
        compare_field("sample_distance", want.sample_distance, got.sample_distance);
        compare_field("average_distance", want.average_distance, got.average_distance);
        compare_field("average_ready", want.average_ready, got.average_ready);
        compare_field("fire_trigger", want.fire_trigger, got.fire_trigger);
        compare_field("count_saturated", want.count_saturated, got.count_saturated);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               echo_level;
  logic               out_valid;
  logic               out_stall;
  logic [TICK_W-1:0]  pulse_ticks;
  logic [DIST_W-1:0]  sample_distance;
  logic [DIST_W-1:0]  average_distance;
  logic               average_ready;
  logic               fire_trigger;
  logic               count_saturated;
  logic               cfg_wr_en;
  logic [SCALE_W-1:0] cfg_wr_data;

  range_scoreboard sb;
  int  items_sent;
  int  burst_left;
  bit  gaps_on;
  bit  hold_start;
  int  idle_cycles;

  echo_pulse_range_averager #(
    .SAMPLES(BLOCK_LEN)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .echo_level       (echo_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .pulse_ticks      (pulse_ticks),
    .sample_distance  (sample_distance),
    .average_distance (average_distance),
    .average_ready    (average_ready),
    .fire_trigger     (fire_trigger),
    .count_saturated  (count_saturated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are checked before the input of the same edge is noted; with the
  // registered stages between input and output the two can never belong to the same item.
  always @(posedge clk) begin
    range_result_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.pulse_ticks      = pulse_ticks;
        got.sample_distance  = sample_distance;
        got.average_distance = average_distance;
        got.average_ready    = average_ready;
        got.fire_trigger     = fire_trigger;
        got.count_saturated  = count_saturated;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) begin
        sb.note_echo_sample(echo_level);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: rotates through stall patterns, and once holds off for a long
  // stretch so that the pipeline fills and stalls the input.
  initial begin
    int  mode;
    int  span;
    int  tick;
    int  hold_left;
    bit  hold_done;
    mode      = 0;
    span      = 100;
    tick      = 0;
    hold_left = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start && !hold_done) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(50, 300);
      end
      span--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        unique case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ((tick % 5) >= 3);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  task automatic send_level(input logic level);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (!gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid   <= 1'b1;
    echo_level <= level;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_pulse(input int high_len, input int low_len);
    repeat (high_len) send_level(1'b1);
    repeat (low_len) send_level(1'b0);
  endtask

  // Mostly well-formed pulses of random length, with some raw line noise.
  task automatic random_traffic(input int count);
    int stop;
    int n;
    stop = items_sent + count;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 80) begin
        n = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 400) : $urandom_range(1, 10);
        send_pulse(n, $urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Stop offering items and wait until every expected result has come back.
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] value);
    drain_block();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.set_scale(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    echo_level  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    items_sent  = 0;
    burst_left  = 0;
    gaps_on     = 1;
    hold_start  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: a rising edge straight out of reset, the shortest pulses,
    // isolated highs and lows, and held outputs between falling edges.
    send_pulse(1, 1);
    send_pulse(2, 1);
    send_pulse(1, 3);
    send_pulse(5, 2);
    send_pulse(1, 1);
    send_pulse(3, 1);
    send_level(1'b0);

    hold_start = 1;
    random_traffic(180);

    // Largest scale, then a stretch with the sender offering items back to
    // back.
    write_scale(16'hFFFF);
    random_traffic(110);
    gaps_on = 0;
    random_traffic(70);
    gaps_on = 1;

    write_scale(16'h0000);
    random_traffic(90);

    write_scale(16'h0001);
    random_traffic(60);

    write_scale(SCALE_W'($urandom_range(0, 65535)));
    random_traffic(130);

    write_scale(SCALE_RESET);
    random_traffic(60);

    drain_block();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
